// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL files of the HSL to RGB converter.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is asserted (active-low reset)
`define ASSERT_CLK(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("%m: assertion failed");

// Clocked assertion that also holds during reset
`define ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("%m: assertion failed");

`endif

// File: hw/rtl/hslc_pkg.sv
// Package of the HSL to RGB converter: pipeline types, fixed-point constants
// and the hue ramp weight function. Depends on nothing.
`default_nettype none

package hslc_pkg;

  localparam int NumStages = 5;
  localparam int NumChan   = 3;

  // Hue offsets, 65536 = one turn
  localparam logic [15:0] ThirdTurn      = 16'd21845;
  localparam logic [15:0] MinusThirdTurn = 16'd43691;

  // Ramp segment limits
  localparam logic [18:0] RampRiseLimit = 19'd65536;   // 6t below one turn
  localparam logic [15:0] RampFallEnd   = 16'd43690;   // last t with 3t below two turns
  localparam logic [18:0] RampFallBase  = 19'd262144;  // 4 * weight one
  localparam logic [16:0] WeightOne     = 17'd65536;

  // Rounding: half of 65535*65536
  localparam logic [49:0] RoundHalf = 50'd2147450880;

  // Folding a value split at bit 16 for division by 65535
  localparam logic [18:0] FoldOne = 19'd65535;
  localparam logic [18:0] FoldTwo = 19'd131070;

  localparam logic [15:0] FullScale = 16'hFFFF;

  typedef logic [16:0] weight_t;

  // Per-stage load enables from the pipeline control
  typedef struct packed {
    logic [NumStages-1:0] load;
  } hslc_ctrl_t;

  // Two blend levels, scaled by 65535*65535
  typedef struct packed {
    logic [31:0] low;
    logic [31:0] diff;
  } hslc_level_t;

  // Piecewise-linear hue ramp, 65536 = full weight
  function automatic weight_t ramp_weight(input logic [15:0] t);
    logic [18:0] six_t;
    logic [18:0] fall;
    weight_t     w;
    six_t = {1'b0, t, 2'b00} + {2'b00, t, 1'b0};
    fall  = RampFallBase - six_t;
    if (six_t < RampRiseLimit) begin
      w = six_t[16:0];
    end else if (!t[15]) begin
      w = WeightOne;
    end else if (t <= RampFallEnd) begin
      w = fall[16:0];
    end else begin
      w = '0;
    end
    return w;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/hslc_pipe_ctrl.sv
// Valid bits and per-stage load enables of the converter pipeline.
// Depends on hslc_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module hslc_pipe_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output hslc_pkg::hslc_ctrl_t ctrl_o
);
  import hslc_pkg::*;

  logic [NumStages-1:0] valid_q, valid_d;
  logic [NumStages-1:0] ready;
  logic [NumStages-1:0] valid_in;

  // A stage takes new data when empty or when the next stage takes its item
  always_comb begin
    ready[NumStages-1] = !valid_q[NumStages-1] || out_ready_i;
    for (int k = NumStages - 2; k >= 0; k--) begin
      ready[k] = !valid_q[k] || ready[k+1];
    end
  end

  assign valid_in = {valid_q[NumStages-2:0], in_valid_i};

  always_comb begin
    for (int k = 0; k < NumStages; k++) begin
      valid_d[k] = ready[k] ? valid_in[k] : valid_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign ctrl_o.load = ready;
  assign in_ready_o  = ready[0];
  assign out_valid_o = valid_q[NumStages-1];

  // Input only stalls when every stage holds an item
  `ASSERT_CLK(a_stall_only_full, clk_i, rst_ni, !in_ready_o |-> (&valid_q))
  // A new result comes from the stage before the output
  `ASSERT_CLK(a_out_from_prev, clk_i, rst_ni, $rose(out_valid_o) |-> $past(valid_q[NumStages-2]))
  // Output drains when taken with nothing behind it
  `ASSERT_CLK(a_out_drains, clk_i, rst_ni,
    (out_valid_o && out_ready_i && !valid_q[NumStages-2]) |=> !out_valid_o)

endmodule

`default_nettype wire

// File: hw/rtl/hslc_levels.sv
// Front stages of the converter: l*s product, blend levels, hue ramp weights.
// Depends on hslc_pkg.
`default_nettype none

module hslc_levels (
  input  logic                    clk_i,
  input  hslc_pkg::hslc_ctrl_t    ctrl_i,
  input  logic [15:0]             hue_i,
  input  logic [15:0]             saturation_i,
  input  logic [15:0]             lightness_i,
  output hslc_pkg::hslc_level_t   level_o,
  output hslc_pkg::weight_t [2:0] weight_o
);
  import hslc_pkg::*;

  // Stage 1: product, scaled lightness, scaled l+s, ramp weights
  logic [31:0]  prod_q;
  logic [31:0]  lf_q;
  logic [32:0]  sumf_q;
  logic         low_half_q;
  weight_t [NumChan-1:0] w_a_q;

  logic [16:0]  sum_ls;
  logic [15:0]  hue_r, hue_b;

  assign sum_ls = {1'b0, lightness_i} + {1'b0, saturation_i};
  assign hue_r  = hue_i + ThirdTurn;
  assign hue_b  = hue_i + MinusThirdTurn;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load[0]) begin
      prod_q     <= 32'(lightness_i) * 32'(saturation_i);
      lf_q       <= {lightness_i, 16'h0000} - {16'h0000, lightness_i};
      sumf_q     <= {sum_ls, 16'h0000} - {16'h0000, sum_ls};
      low_half_q <= !lightness_i[15];
      w_a_q[0]   <= ramp_weight(hue_r);
      w_a_q[1]   <= ramp_weight(hue_i);
      w_a_q[2]   <= ramp_weight(hue_b);
    end
  end

  // Stage 2: high level, then low level and spread
  logic [31:0] high;
  logic [32:0] high_up;
  logic [32:0] low_w, diff_w;
  hslc_level_t level_q;
  weight_t [NumChan-1:0] w_b_q;

  assign high_up = sumf_q - {1'b0, prod_q};
  assign high    = low_half_q ? (lf_q + prod_q) : high_up[31:0];
  assign low_w   = {lf_q, 1'b0} - {1'b0, high};
  assign diff_w  = {high, 1'b0} - {lf_q, 1'b0};

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load[1]) begin
      level_q.low  <= low_w[31:0];
      level_q.diff <= diff_w[31:0];
      w_b_q        <= w_a_q;
    end
  end

  assign level_o  = level_q;
  assign weight_o = w_b_q;

endmodule

`default_nettype wire

// File: hw/rtl/hslc_blend.sv
// One color channel: weighted blend of the levels, rounding, /65535, clamp.
// Depends on hslc_pkg.
`default_nettype none

module hslc_blend (
  input  logic                  clk_i,
  input  hslc_pkg::hslc_ctrl_t  ctrl_i,
  input  hslc_pkg::hslc_level_t level_i,
  input  hslc_pkg::weight_t     weight_i,
  output logic [15:0]           color_o
);
  import hslc_pkg::*;

  // Stage 3: spread times weight
  logic [48:0] mult_q;
  logic [31:0] low_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load[2]) begin
      mult_q <= 49'(level_i.diff) * 49'(weight_i);
      low_q  <= level_i.low;
    end
  end

  // Stage 4: add low level and rounding offset, drop the low 16 bits
  logic [49:0] num;
  logic [33:0] q1_q;

  assign num = {2'b00, low_q, 16'h0000} + {1'b0, mult_q} + RoundHalf;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load[3]) begin
      q1_q <= num[49:16];
    end
  end

  // Stage 5: divide by 65535 via folding the halves, then clamp
  logic [17:0] hi;
  logic [15:0] lo;
  logic [18:0] fold;
  logic [18:0] quot;
  logic [1:0]  extra;
  logic [15:0] color_q, color_d;

  assign hi   = q1_q[33:16];
  assign lo   = q1_q[15:0];
  assign fold = {1'b0, hi} + {3'b000, lo};

  always_comb begin
    if (fold >= FoldTwo) begin
      extra = 2'd2;
    end else if (fold >= FoldOne) begin
      extra = 2'd1;
    end else begin
      extra = 2'd0;
    end
  end

  assign quot    = {1'b0, hi} + {17'd0, extra};
  assign color_d = (quot[18:16] != 3'd0) ? FullScale : quot[15:0];

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load[4]) begin
      color_q <= color_d;
    end
  end

  assign color_o = color_q;

endmodule

`default_nettype wire

// File: hw/rtl/hsl_to_rgb_converter_unit.sv
// Top level of the HSL to RGB converter: five-stage pipeline, three channels.
// Depends on hslc_pkg, hslc_pipe_ctrl, hslc_levels and hslc_blend.
//
//   channel  dir  payload (tdata, low bit first)
//   s_axis   in   hue[15:0], saturation[31:16], lightness[47:32]
//   m_axis   out  red[15:0], green[31:16], blue[47:32]
//
// One pixel per cycle sustained while m_axis_tready stays high; a result
// passes the five register stages (product, levels, weight multiply,
// rounding add, divide-and-clamp) before m_axis_tvalid rises.
// Reset clears only the stage valid bits; data registers are not reset.
// Each stage has its own ready, so a stall at m_axis fills empty stages
// before s_axis_tready drops; no item is lost or repeated.
`default_nettype none

module hsl_to_rgb_converter_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // hue[15:0], saturation[31:16], lightness[47:32]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata    // red[15:0], green[31:16], blue[47:32]
);
  import hslc_pkg::*;

  hslc_ctrl_t            ctrl;
  hslc_level_t           level;
  weight_t [NumChan-1:0] weight;
  logic [NumChan-1:0][15:0] color;

  // Stage valid bits and load enables
  hslc_pipe_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .ctrl_o      (ctrl)
  );

  // Shared front stages
  hslc_levels u_levels (
    .clk_i        (clk_i),
    .ctrl_i       (ctrl),
    .hue_i        (s_axis_tdata[15:0]),
    .saturation_i (s_axis_tdata[31:16]),
    .lightness_i  (s_axis_tdata[47:32]),
    .level_o      (level),
    .weight_o     (weight)
  );

  // Red, green, blue back stages
  for (genvar c = 0; c < NumChan; c++) begin : g_chan
    hslc_blend u_blend (
      .clk_i    (clk_i),
      .ctrl_i   (ctrl),
      .level_i  (level),
      .weight_i (weight[c]),
      .color_o  (color[c])
    );
  end

  assign m_axis_tdata = {color[2], color[1], color[0]};

endmodule

`default_nettype wire
